### src/kea_pkg.sv
// ----------------------------------------------------------------------------
// kea_pkg: shared types and constants for the key edge / auto-repeat table
// Item and result layouts, item kind codes and parameter defaults.
// ----------------------------------------------------------------------------
package kea_pkg;

    localparam int KEY_INDEX_BITS = 8;
    localparam int PERIOD_BITS    = 16;

    localparam int DEF_NUM_KEYS   = 256;
    localparam int DEF_COUNT_BITS = 16;

    localparam logic [1:0] KIND_SAMPLE     = 2'd0;
    localparam logic [1:0] KIND_QUERY      = 2'd1;
    localparam logic [1:0] KIND_SET_REPEAT = 2'd2;
    localparam logic [1:0] KIND_SET_PERIOD = 2'd3;

    typedef struct packed {
        logic [1:0]                kind;
        logic [KEY_INDEX_BITS-1:0] key_index;
        logic                      pressed;
        logic                      clear_on_fire;
        logic                      repeat_enable;
        logic [PERIOD_BITS-1:0]    repeat_interval;
    } t_in_item;

    typedef struct packed {
        logic held;
        logic pushed;
        logic repeat_on;
    } t_out_item;

endpackage

### src/kea_if.sv
// ----------------------------------------------------------------------------
// kea_if: valid/ready channels of the key table
// One channel for incoming items and one for results.
// ----------------------------------------------------------------------------
interface kea_item_if;
    logic              valid;
    logic              ready;
    kea_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface kea_result_if;
    logic               valid;
    logic               ready;
    kea_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/key_edge_autorepeat_table.sv
// ----------------------------------------------------------------------------
// key_edge_autorepeat_table: per-key press edge detector with auto-repeat
// Key state table in one RAM, read-modify-write of one entry per item.
// ----------------------------------------------------------------------------
// The block sustains one item per clock cycle while the result channel is not
// stalled, set by a single read-modify-write of the key table: an accepted
// item reads its entry, and the modify stage writes the modified entry back and
// loads the result register once that register is free. A write still in
// flight is forwarded to a read of the same key in the same cycle. After reset
// the block clears the table entry by entry and accepts no item during that
// pass. An index at or beyond NUM_KEYS leaves the table untouched and yields
// a result of all zeros.
module key_edge_autorepeat_table #(
    parameter int NUM_KEYS   = kea_pkg::DEF_NUM_KEYS,
    parameter int COUNT_BITS = kea_pkg::DEF_COUNT_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    kea_item_if.sink     i_item,
    kea_result_if.source o_result
);
    import kea_pkg::*;

    localparam int AW      = $clog2(NUM_KEYS);
    localparam int IW      = (AW > KEY_INDEX_BITS) ? AW : KEY_INDEX_BITS;
    localparam int ENTRY_W = PERIOD_BITS + COUNT_BITS + 3;
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_KEYS - 1);

    // Clearing pass
    logic          r_clearing;
    logic          n_clearing;
    logic [AW-1:0] r_clr_addr;
    logic [AW-1:0] n_clr_addr;

    // Modify stage
    logic          r_b_valid;
    logic          n_b_valid;
    t_in_item      r_b_item;
    logic [AW-1:0] r_b_addr;
    logic          r_b_in_range;
    logic          r_b_hit;

    // Forwarded copy of the last written entry
    logic [ENTRY_W-1:0] r_fwd_data;

    // Result register
    logic      r_out_valid;
    logic      n_out_valid;
    t_out_item r_out_data;

    logic               accept;
    logic               b_done;
    logic [IW:0]        idx_ext;
    logic               in_range;
    logic [AW-1:0]      in_addr;
    logic [ENTRY_W-1:0] rd_data;
    logic [ENTRY_W-1:0] cur_entry;
    logic [ENTRY_W-1:0] upd_entry;
    logic               upd_we;
    t_out_item          upd_result;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    assign idx_ext  = (IW + 1)'(i_item.data.key_index);
    assign in_range = idx_ext < (IW + 1)'(NUM_KEYS);
    assign in_addr  = idx_ext[AW-1:0];

    assign b_done       = r_b_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_clearing && (!r_b_valid || b_done);
    assign accept       = i_item.valid && i_item.ready;

    assign cur_entry = r_b_hit ? r_fwd_data : rd_data;

    kea_entry_update #(
        .COUNT_BITS (COUNT_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_update (
        .i_entry    (cur_entry),
        .i_item     (r_b_item),
        .i_in_range (r_b_in_range),
        .o_entry    (upd_entry),
        .o_we       (upd_we),
        .o_result   (upd_result)
    );

    always_comb begin
        if (r_clearing) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else begin
            wr_en   = b_done && upd_we;
            wr_addr = r_b_addr;
            wr_data = upd_entry;
        end
    end

    kea_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_KEYS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (accept),
        .i_rd_addr (in_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_clearing = r_clearing;
        n_clr_addr = r_clr_addr;
        if (r_clearing) begin
            n_clr_addr = r_clr_addr + AW'(1);
            if (r_clr_addr == LAST_ADDR) begin
                n_clearing = 1'b0;
            end
        end
        n_b_valid   = accept || (r_b_valid && !b_done);
        n_out_valid = b_done || (r_out_valid && !o_result.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_clearing  <= n_clearing;
            r_clr_addr  <= n_clr_addr;
            r_b_valid   <= n_b_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_item     <= i_item.data;
            r_b_addr     <= in_addr;
            r_b_in_range <= in_range;
            // The RAM returns the old entry when the same key is written
            // in the cycle of the read, so the written value is used instead.
            r_b_hit      <= wr_en && (wr_addr == in_addr);
        end
        if (wr_en) begin
            r_fwd_data <= wr_data;
        end
        if (b_done) begin
            r_out_data <= upd_result;
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out_data;

    a_idle_while_clearing : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> (!r_b_valid && !r_out_valid))
        else $error("item in flight during the table clearing pass");

    a_done_loads_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_done |=> r_out_valid)
        else $error("finished item did not reach the result register");

    a_stage_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && !b_done) |=> (r_b_valid && $stable(r_b_item) && $stable(r_b_hit)))
        else $error("stalled modify stage lost its item");

    a_forward_taken : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && wr_en && (wr_addr == in_addr)) |=> r_b_hit)
        else $error("write to the key being read was not forwarded");

endmodule

### src/kea_ram.sv
// ----------------------------------------------------------------------------
// kea_ram: generic single-clock RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module kea_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/kea_entry_update.sv
// ----------------------------------------------------------------------------
// kea_entry_update: modify step of one key entry
// Applies one item to the entry read from the table and forms the result.
// ----------------------------------------------------------------------------
module kea_entry_update #(
    parameter int COUNT_BITS = 16,
    parameter int ENTRY_W    = 35
) (
    input  logic [ENTRY_W-1:0] i_entry,
    input  kea_pkg::t_in_item  i_item,
    input  logic               i_in_range,
    output logic [ENTRY_W-1:0] o_entry,
    output logic               o_we,
    output kea_pkg::t_out_item o_result
);
    import kea_pkg::*;

    // Entry layout, low to high: level now, level before, repeat flag,
    // repeat counter, repeat period.
    localparam int NOW_BIT    = 0;
    localparam int BEFORE_BIT = 1;
    localparam int FLAG_BIT   = 2;
    localparam int CNT_LO     = 3;
    localparam int PER_LO     = CNT_LO + COUNT_BITS;
    localparam int CMP_W      = (COUNT_BITS > PERIOD_BITS) ? COUNT_BITS : PERIOD_BITS;

    logic                   now_lvl;
    logic                   before_lvl;
    logic                   flag;
    logic [COUNT_BITS-1:0]  count;
    logic [PERIOD_BITS-1:0] period;
    logic                   pushed;
    logic                   due;

    assign due = (CMP_W'(i_entry[CNT_LO +: COUNT_BITS])
                  >= CMP_W'(i_entry[PER_LO +: PERIOD_BITS]));

    always_comb begin
        now_lvl    = i_entry[NOW_BIT];
        before_lvl = i_entry[BEFORE_BIT];
        flag       = i_entry[FLAG_BIT];
        count      = i_entry[CNT_LO +: COUNT_BITS];
        period     = i_entry[PER_LO +: PERIOD_BITS];
        pushed     = 1'b0;
        case (i_item.kind)
            KIND_SAMPLE: begin
                before_lvl = now_lvl;
                if (flag && (count != {COUNT_BITS{1'b1}})) begin
                    count = count + COUNT_BITS'(1);
                end
                now_lvl = i_item.pressed;
            end
            KIND_QUERY: begin
                if (!flag) begin
                    pushed = !before_lvl && now_lvl;
                end else if (now_lvl && due) begin
                    pushed = 1'b1;
                    if (i_item.clear_on_fire) begin
                        count = '0;
                    end
                end
            end
            KIND_SET_REPEAT: begin
                flag  = i_item.repeat_enable;
                count = '0;
            end
            KIND_SET_PERIOD: begin
                period = i_item.repeat_interval;
            end
            default: begin
                period = i_entry[PER_LO +: PERIOD_BITS];
            end
        endcase
    end

    assign o_entry = {period, count, flag, before_lvl, now_lvl};
    assign o_we    = i_in_range;

    // A key outside the table reports all zero.
    assign o_result.held      = i_in_range & now_lvl;
    assign o_result.pushed    = i_in_range & pushed;
    assign o_result.repeat_on = i_in_range & flag;

endmodule
